[sv/eigdc_pkg.sv]
// ----------------------------------------------------------------------------
// eigdc_pkg
// Shared types and constants of the eigenvector direction color block.
// ----------------------------------------------------------------------------
package eigdc_pkg;

  localparam int unsigned FIELD_W    = 16;
  localparam int unsigned ACC_W      = 36;
  localparam int unsigned FRAC_BITS  = 15;
  localparam int unsigned UNIT_Q     = 16;
  localparam int unsigned NORM_BIT   = 30;
  localparam int unsigned SQ_W       = 62;
  localparam int unsigned ROOT_W     = 63;
  localparam int unsigned N_W        = 32;
  localparam int unsigned REM_W      = 33;
  localparam int unsigned U_W        = 17;
  localparam int unsigned PROD_W     = 34;
  localparam int unsigned SQRT_STEPS = 32;
  localparam int unsigned DIV_STEPS  = 17;
  localparam int unsigned CFG_IDX_W  = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_SHIFT_MODE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_AI_WEIGHTING = 2'd1;

  localparam logic [U_W-1:0] ONE_Q = 17'h10000;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_ACC,
    OP_MAG,
    OP_NORM,
    OP_SQ,
    OP_SQRT_INIT,
    OP_SQRT,
    OP_DIV_INIT,
    OP_DIV,
    OP_MUL,
    OP_BYTE,
    OP_EMIT
  } op_e;

  typedef struct packed {
    op_e        op;
    logic [1:0] sel;
  } cmd_t;

  typedef struct packed {
    logic norm_big;
    logic last;
    logic out_free;
  } sts_t;

endpackage

[sv/eigdc_ctrl.sv]
// ----------------------------------------------------------------------------
// eigdc_ctrl
// Sequencer: accumulate corners, then normalize, square root, divide, color.
// ----------------------------------------------------------------------------
module eigdc_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  eigdc_pkg::sts_t   sts_i,
  output eigdc_pkg::cmd_t   cmd_o
);

  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_ACC   = 4'd1;
  localparam logic [3:0] ST_MAG   = 4'd2;
  localparam logic [3:0] ST_NORM  = 4'd3;
  localparam logic [3:0] ST_SQ    = 4'd4;
  localparam logic [3:0] ST_SQI   = 4'd5;
  localparam logic [3:0] ST_SQRT  = 4'd6;
  localparam logic [3:0] ST_DIVI  = 4'd7;
  localparam logic [3:0] ST_DIV   = 4'd8;
  localparam logic [3:0] ST_MUL   = 4'd9;
  localparam logic [3:0] ST_BYTE  = 4'd10;
  localparam logic [3:0] ST_EMIT  = 4'd11;

  logic [3:0] state_q, state_d;
  logic [4:0] cnt_q, cnt_d;
  logic [1:0] sel_q, sel_d;

  assign in_stall_o = (state_q != ST_IDLE);

  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    sel_d      = sel_q;
    cmd_o.op   = eigdc_pkg::OP_NONE;
    cmd_o.sel  = sel_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.op = eigdc_pkg::OP_LOAD;
          sel_d    = 2'd0;
          state_d  = ST_ACC;
        end
      end
      ST_ACC: begin
        cmd_o.op = eigdc_pkg::OP_ACC;
        sel_d    = sel_q + 2'd1;
        if (sel_q == 2'd3) begin
          state_d = sts_i.last ? ST_MAG : ST_IDLE;
        end
      end
      ST_MAG: begin
        cmd_o.op = eigdc_pkg::OP_MAG;
        state_d  = ST_NORM;
      end
      ST_NORM: begin
        if (sts_i.norm_big) begin
          cmd_o.op = eigdc_pkg::OP_NORM;
        end else begin
          sel_d   = 2'd0;
          state_d = ST_SQ;
        end
      end
      ST_SQ: begin
        cmd_o.op = eigdc_pkg::OP_SQ;
        sel_d    = sel_q + 2'd1;
        if (sel_q == 2'd2) begin
          state_d = ST_SQI;
        end
      end
      ST_SQI: begin
        cmd_o.op = eigdc_pkg::OP_SQRT_INIT;
        cnt_d    = '0;
        state_d  = ST_SQRT;
      end
      ST_SQRT: begin
        cmd_o.op = eigdc_pkg::OP_SQRT;
        cnt_d    = cnt_q + 5'd1;
        if (cnt_q == 5'(eigdc_pkg::SQRT_STEPS - 1)) begin
          sel_d   = 2'd0;
          state_d = ST_DIVI;
        end
      end
      ST_DIVI: begin
        cmd_o.op = eigdc_pkg::OP_DIV_INIT;
        cnt_d    = '0;
        state_d  = ST_DIV;
      end
      ST_DIV: begin
        cmd_o.op = eigdc_pkg::OP_DIV;
        cnt_d    = cnt_q + 5'd1;
        if (cnt_q == 5'(eigdc_pkg::DIV_STEPS - 1)) begin
          state_d = ST_MUL;
        end
      end
      ST_MUL: begin
        cmd_o.op = eigdc_pkg::OP_MUL;
        state_d  = ST_BYTE;
      end
      ST_BYTE: begin
        cmd_o.op = eigdc_pkg::OP_BYTE;
        if (sel_q == 2'd2) begin
          state_d = ST_EMIT;
        end else begin
          sel_d   = sel_q + 2'd1;
          state_d = ST_DIVI;
        end
      end
      ST_EMIT: begin
        if (sts_i.out_free) begin
          cmd_o.op = eigdc_pkg::OP_EMIT;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
      sel_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      sel_q   <= sel_d;
    end
  end

`ifndef SYNTHESIS
  a_div_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_DIV |-> cnt_q <= 5'(eigdc_pkg::DIV_STEPS - 1))
    else $error("divider step count overrun");
  a_sel_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SQ || state_q == ST_DIV) |-> sel_q != 2'd3)
    else $error("component select out of range");
  a_stall_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.op == eigdc_pkg::OP_LOAD |=> in_stall_o)
    else $error("load did not leave idle");
`endif

endmodule

[sv/eigdc_dp.sv]
// ----------------------------------------------------------------------------
// eigdc_dp
// Datapath: accumulators, magnitude normalize, sum of squares, bit-serial
// square root, restoring divider, brightness scaling and output register.
// ----------------------------------------------------------------------------
module eigdc_dp (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  eigdc_pkg::cmd_t                        cmd_i,
  output eigdc_pkg::sts_t                        sts_o,
  input  logic                                   cfg_we_i,
  input  logic [eigdc_pkg::CFG_IDX_W-1:0]        cfg_index_i,
  input  logic                                   cfg_data_i,
  input  logic [15:0]                            corner_weight_i,
  input  logic signed [15:0]                     vec_x_i,
  input  logic signed [15:0]                     vec_y_i,
  input  logic signed [15:0]                     vec_z_i,
  input  logic signed [15:0]                     corner_aniso_i,
  input  logic                                   last_corner_i,
  output logic                                   out_valid_o,
  input  logic                                   out_stall_i,
  output logic [7:0]                             red_o,
  output logic [7:0]                             green_o,
  output logic [7:0]                             blue_o
);

  localparam int unsigned ACC_W  = eigdc_pkg::ACC_W;
  localparam int unsigned ROOT_W = eigdc_pkg::ROOT_W;
  localparam int unsigned REM_W  = eigdc_pkg::REM_W;
  localparam int unsigned U_W    = eigdc_pkg::U_W;
  localparam int unsigned PROD_W = eigdc_pkg::PROD_W;
  localparam int unsigned NB     = eigdc_pkg::NORM_BIT;
  localparam int unsigned AHI    = 2 * eigdc_pkg::FRAC_BITS;
  localparam int unsigned ALO    = AHI - eigdc_pkg::UNIT_Q;

  logic                 shift_mode_q, ai_weighting_q;
  logic [15:0]          w_q;
  logic signed [15:0]   fld_q [4];
  logic                 last_q;
  logic [ACC_W-1:0]     sum_q [4];
  logic [ACC_W-1:0]     mag_q [3];
  logic [2:0]           neg_q;
  logic [U_W-1:0]       a_q;
  logic [eigdc_pkg::SQ_W-1:0] s2_q;
  logic [ROOT_W-1:0]    rad_q, root_q, bit_q;
  logic [REM_W-1:0]     rem_q;
  logic [U_W-1:0]       quo_q;
  logic [PROD_W-1:0]    prod_q;
  logic [7:0]           col_q [3];
  logic                 out_valid_q;
  logic [7:0]           red_q, green_q, blue_q;

  logic signed [15:0]   fld;
  logic signed [32:0]   pacc;
  logic [ACC_W-1:0]     sum_sel;
  logic [ACC_W-1:0]     mag_sel;
  logic                 neg_sel;
  logic [59:0]          sq;
  logic [ROOT_W-1:0]    trial;
  logic [REM_W-1:0]     nd, diff;
  logic                 ge;
  logic [U_W-1:0]       u, m;
  logic [U_W:0]         msum;
  logic [PROD_W+7:0]    scaled;
  logic [ACC_W-1:0]     sa;
  logic [U_W-1:0]       a_new;
  logic                 root_zero;

  always_comb begin
    unique case (cmd_i.sel)
      2'd0:    fld = fld_q[0];
      2'd1:    fld = fld_q[1];
      2'd2:    fld = fld_q[2];
      default: fld = fld_q[3];
    endcase
    unique case (cmd_i.sel)
      2'd0:    begin mag_sel = mag_q[0]; neg_sel = neg_q[0]; end
      2'd1:    begin mag_sel = mag_q[1]; neg_sel = neg_q[1]; end
      default: begin mag_sel = mag_q[2]; neg_sel = neg_q[2]; end
    endcase
  end

  assign sum_sel   = sum_q[cmd_i.sel];
  assign pacc      = $signed({1'b0, w_q}) * fld;
  assign sq        = mag_sel[NB-1:0] * mag_sel[NB-1:0];
  assign trial     = root_q + bit_q;
  assign nd        = {1'b0, root_q[eigdc_pkg::N_W-1:0]};
  assign ge        = (rem_q >= nd);
  assign diff      = ge ? (rem_q - nd) : rem_q;
  assign root_zero = (root_q[eigdc_pkg::N_W-1:0] == '0);
  assign u         = root_zero ? '0 : quo_q;
  assign msum      = neg_sel ? ({1'b0, eigdc_pkg::ONE_Q} - {1'b0, u})
                             : ({1'b0, eigdc_pkg::ONE_Q} + {1'b0, u});
  assign m         = shift_mode_q ? msum[U_W:1] : u;
  // x * 255 as x * 256 - x
  assign scaled    = {prod_q, 8'd0} - {8'd0, prod_q};
  assign sa        = sum_q[3];

  always_comb begin
    if (!ai_weighting_q) begin
      a_new = eigdc_pkg::ONE_Q;
    end else if (sa[ACC_W-1]) begin
      a_new = '0;
    end else if (|sa[ACC_W-2:AHI]) begin
      a_new = eigdc_pkg::ONE_Q;
    end else begin
      a_new = {1'b0, sa[AHI-1:ALO]};
    end
  end

  assign sts_o.norm_big = (|mag_q[0][ACC_W-1:NB]) | (|mag_q[1][ACC_W-1:NB])
                        | (|mag_q[2][ACC_W-1:NB]);
  assign sts_o.last     = last_q;
  assign sts_o.out_free = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shift_mode_q   <= 1'b0;
      ai_weighting_q <= 1'b0;
      out_valid_q    <= 1'b0;
      for (int i = 0; i < 4; i++) begin
        sum_q[i] <= '0;
      end
    end else begin
      if (cfg_we_i) begin
        if (cfg_index_i == eigdc_pkg::CFG_SHIFT_MODE) begin
          shift_mode_q <= cfg_data_i;
        end
        if (cfg_index_i == eigdc_pkg::CFG_AI_WEIGHTING) begin
          ai_weighting_q <= cfg_data_i;
        end
      end
      if (cmd_i.op == eigdc_pkg::OP_EMIT) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      if (cmd_i.op == eigdc_pkg::OP_ACC) begin
        sum_q[cmd_i.sel] <= sum_sel + {{(ACC_W-33){pacc[32]}}, pacc};
      end else if (cmd_i.op == eigdc_pkg::OP_MAG) begin
        for (int i = 0; i < 4; i++) begin
          sum_q[i] <= '0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (cmd_i.op)
      eigdc_pkg::OP_LOAD: begin
        w_q      <= corner_weight_i;
        fld_q[0] <= vec_x_i;
        fld_q[1] <= vec_y_i;
        fld_q[2] <= vec_z_i;
        fld_q[3] <= corner_aniso_i;
        last_q   <= last_corner_i;
      end
      eigdc_pkg::OP_MAG: begin
        for (int i = 0; i < 3; i++) begin
          mag_q[i] <= sum_q[i][ACC_W-1] ? (ACC_W'(0) - sum_q[i]) : sum_q[i];
          neg_q[i] <= sum_q[i][ACC_W-1];
        end
        a_q  <= a_new;
        s2_q <= '0;
      end
      eigdc_pkg::OP_NORM: begin
        for (int i = 0; i < 3; i++) begin
          mag_q[i] <= mag_q[i] >> 1;
        end
      end
      eigdc_pkg::OP_SQ: begin
        s2_q <= s2_q + {2'b00, sq};
      end
      eigdc_pkg::OP_SQRT_INIT: begin
        rad_q  <= {1'b0, s2_q};
        root_q <= '0;
        // starts at 4^31 so that 32 steps end on the 4^0 place
        bit_q  <= {1'b1, {(ROOT_W-1){1'b0}}};
      end
      eigdc_pkg::OP_SQRT: begin
        if (rad_q >= trial) begin
          rad_q  <= rad_q - trial;
          root_q <= (root_q >> 1) + bit_q;
        end else begin
          root_q <= root_q >> 1;
        end
        bit_q <= bit_q >> 2;
      end
      eigdc_pkg::OP_DIV_INIT: begin
        rem_q <= {3'b000, mag_sel[NB-1:0]};
        quo_q <= '0;
      end
      eigdc_pkg::OP_DIV: begin
        rem_q <= {diff[REM_W-2:0], 1'b0};
        quo_q <= {quo_q[U_W-2:0], ge};
      end
      eigdc_pkg::OP_MUL: begin
        prod_q <= m * a_q;
      end
      eigdc_pkg::OP_BYTE: begin
        col_q[cmd_i.sel] <= scaled[39:32];
      end
      eigdc_pkg::OP_EMIT: begin
        red_q   <= col_q[0];
        green_q <= col_q[1];
        blue_q  <= col_q[2];
      end
      default: begin
      end
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign red_o       = red_q;
  assign green_o     = green_q;
  assign blue_o      = blue_q;

`ifndef SYNTHESIS
  a_root_fits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.op == eigdc_pkg::OP_DIV_INIT |-> root_q[ROOT_W-1:eigdc_pkg::N_W] == '0)
    else $error("square root wider than divisor");
  a_unit_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.op == eigdc_pkg::OP_MUL |-> (root_zero || quo_q <= eigdc_pkg::ONE_Q))
    else $error("unit component above one");
  a_sq_norm: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.op == eigdc_pkg::OP_SQ |-> !sts_o.norm_big)
    else $error("squaring before normalize finished");
  a_emit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.op == eigdc_pkg::OP_EMIT |-> !(out_valid_q && out_stall_i))
    else $error("result overwritten while stalled");
`endif

endmodule

[sv/eigenvector_direction_color.sv]
// ----------------------------------------------------------------------------
// eigenvector_direction_color
// Fiber point color from weighted eigenvector and anisotropy sums.
// ----------------------------------------------------------------------------
// One corner per transaction. A corner that is not last is captured, then
// one shared 17x16 multiplier runs over x, y, z and anisotropy. After the
// last corner come the magnitudes, k = 0..6 normalize shifts, the sum of
// squares, the bit-serial square root (32 steps) and, per channel, the
// restoring divider (17 steps), brightness scaling and the byte. The
// result sits in an output register, so the next point's corners are taken
// while the color waits to be taken; a point finishing while the previous
// color is still held waits until that color is taken. Config writes are
// always ready.
module eigenvector_direction_color (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [15:0]                         corner_weight_i,
  input  logic signed [15:0]                  vec_x_i,
  input  logic signed [15:0]                  vec_y_i,
  input  logic signed [15:0]                  vec_z_i,
  input  logic signed [15:0]                  corner_aniso_i,
  input  logic                                last_corner_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [7:0]                          red_o,
  output logic [7:0]                          green_o,
  output logic [7:0]                          blue_o,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [eigdc_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic                                cfg_data_i
);

  eigdc_pkg::cmd_t cmd;
  eigdc_pkg::sts_t sts;

  assign cfg_ready_o = 1'b1;

  eigdc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  eigdc_dp u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .cfg_we_i        (cfg_valid_i & cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .corner_weight_i (corner_weight_i),
    .vec_x_i         (vec_x_i),
    .vec_y_i         (vec_y_i),
    .vec_z_i         (vec_z_i),
    .corner_aniso_i  (corner_aniso_i),
    .last_corner_i   (last_corner_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .red_o           (red_o),
    .green_o         (green_o),
    .blue_o          (blue_o)
  );

endmodule
